### hdl/uhfdd_pkg.sv
// ----------------------------------------------------------------------------
// uhfdd_pkg
// Shared constants, codes and types of the UHF reader deframer with tag table.
// ----------------------------------------------------------------------------
package uhfdd_pkg;

  localparam int MAX_TAG_ENTRIES = 32;
  localparam int MAX_EPC_BYTES   = 12;
  localparam int FRAME_BYTES     = 256;

  localparam logic [7:0] HDR_BYTE    = 8'hBB;
  localparam logic [7:0] END_BYTE    = 8'h7E;
  localparam logic [7:0] NOTIFY_TYPE = 8'h02;
  localparam logic [7:0] NOTIFY_CMD  = 8'h22;

  localparam int DROP_FILL       = 255;
  localparam int MIN_PROCESS_LEN = 7;
  localparam int MIN_END_FILL    = 5;
  localparam int TYPE_POS        = 1;
  localparam int CMD_POS         = 2;
  localparam int LEN_POS         = 4;
  localparam int EPC_OVERHEAD    = 5;
  localparam int EPC_START       = 8;

  localparam int DROP_LIMIT = (FRAME_BYTES - 1 < DROP_FILL) ? FRAME_BYTES - 1 : DROP_FILL;

  localparam int FILL_W = $clog2(FRAME_BYTES);
  localparam int EL_W   = $clog2(MAX_EPC_BYTES + 1);
  localparam int POS_W  = (MAX_EPC_BYTES > 1) ? $clog2(MAX_EPC_BYTES) : 1;
  localparam int SLOT_W = (MAX_TAG_ENTRIES > 1) ? $clog2(MAX_TAG_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_TAG_ENTRIES + 1);
  localparam int ROW_W  = EL_W + 8 * MAX_EPC_BYTES;

  // Widths of the result fields.
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 5;
  localparam int LEN_OUT_W  = 4;
  localparam int POS_OUT_W  = 4;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NEW     = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LRD,
    ST_LWR,
    ST_SRD,
    ST_SCMP,
    ST_DECIDE,
    ST_EMIT
  } state_e;

endpackage

### hdl/uhfdd_if.sv
// ----------------------------------------------------------------------------
// uhfdd_if
// Valid/ready channels of the deframer: received bytes in, tag reports out.
// ----------------------------------------------------------------------------
interface uhfdd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface uhfdd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] slot;
  logic [3:0] epc_length;
  logic [3:0] byte_position;
  logic [7:0] epc_byte;
  logic       last;

  modport source (output valid, status, slot, epc_length, byte_position, epc_byte, last,
                  input ready);
  modport sink (input valid, status, slot, epc_length, byte_position, epc_byte, last,
                output ready);
endinterface

### hdl/uhf_reader_frame_parser_tag_dedupe.sv
// ----------------------------------------------------------------------------
// uhf_reader_frame_parser_tag_dedupe
// Deframes reader notifications and reports each EPC against a tag table.
// ----------------------------------------------------------------------------
// rx_i carries one beat per received byte (command 0) or a table clear
// (command 1). Bytes are gathered into a frame memory; a frame opens on 0xBB
// and closes on 0x7E once more than five bytes are stored. A closed
// notification frame with a sane EPC is looked up in a tag table of one
// memory row per slot (length plus all EPC bytes), one row at a time.
// tx_o then gives one beat per EPC byte (one beat for an empty EPC) with
// status, slot and a last flag.
// A byte that does not close a frame leaves rx_i ready. After a closing
// notification frame rx_i is not ready while the block works: it reads and
// then writes each EPC byte to copy the EPC out of the frame memory, reads
// and then compares each table row, adds one more read and a decision step
// when no row matches, then loads each result beat. rx_i stays busy until
// the last beat is loaded, longer while tx_o stalls.
// The result register lets rx_i take bytes while the last beat still waits.
// A stalled receiver simply holds tx_o and the report pauses.
// Reset empties the table and leaves the block idle; memories are not
// cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module uhf_reader_frame_parser_tag_dedupe (
  input  logic clk_i,
  input  logic rst_ni,
  uhfdd_in_if.sink    rx_i,
  uhfdd_out_if.source tx_o
);

  localparam int FW = uhfdd_pkg::FILL_W;
  localparam int EW = uhfdd_pkg::EL_W;
  localparam int PW = uhfdd_pkg::POS_W;
  localparam int SW = uhfdd_pkg::SLOT_W;
  localparam int CW = uhfdd_pkg::CNT_W;
  localparam int RW = uhfdd_pkg::ROW_W;
  localparam int NB = uhfdd_pkg::MAX_EPC_BYTES;

  uhfdd_pkg::state_e  st_q, st_d;
  uhfdd_pkg::status_e status_q, status_d;

  logic          recv_q, recv_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    type_q, cmd_q, dlen_q;
  logic [EW-1:0] el_q, el_d;
  logic [EW-1:0] k_q, k_d;
  logic [CW-1:0] i_q, i_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [EW-1:0] j_q, j_d;
  logic          out_v_q, out_v_d;
  logic [7:0]    buf_q [NB];

  // Frame memory and tag table memory.
  logic [7:0]    fmem [uhfdd_pkg::FRAME_BYTES];
  logic [7:0]    fm_rdata_q;
  logic [FW-1:0] fm_waddr, fm_raddr;
  logic          fm_we;
  logic [RW-1:0] tmem [uhfdd_pkg::MAX_TAG_ENTRIES];
  logic [RW-1:0] tm_rdata_q, tm_wdata;
  logic          tm_we;

  logic          rx_acc, is_start, is_recv, close, frame_ok, out_ld, match, last_item;
  logic [FW-1:0] idx;
  logic [FW:0]   nfill;
  logic [7:0]    el8;
  logic [8:0]    epc_end;
  logic [EW:0]   item_cnt;
  logic [NB-1:0] byte_eq;
  logic [7:0]    out_byte;

  assign rx_acc   = rx_i.valid && rx_i.ready;
  assign rx_i.ready = (st_q == uhfdd_pkg::ST_IDLE);

  // Frame byte placement.
  assign is_start = (rx_i.rx_byte == uhfdd_pkg::HDR_BYTE) && !recv_q;
  assign is_recv  = recv_q || is_start;
  assign idx      = is_start ? '0 : fill_q;
  assign nfill    = {1'b0, idx} + (FW+1)'(1);
  assign close    = (rx_i.rx_byte == uhfdd_pkg::END_BYTE) &&
                    (nfill > (FW+1)'(uhfdd_pkg::MIN_END_FILL));

  // Notification checks on the closing frame.
  assign el8     = dlen_q - 8'(uhfdd_pkg::EPC_OVERHEAD);
  assign epc_end = 9'(uhfdd_pkg::EPC_START) + {1'b0, el8};
  assign frame_ok = (nfill >= (FW+1)'(uhfdd_pkg::MIN_PROCESS_LEN)) &&
                    (type_q == uhfdd_pkg::NOTIFY_TYPE) &&
                    (cmd_q == uhfdd_pkg::NOTIFY_CMD) &&
                    (dlen_q >= 8'(uhfdd_pkg::EPC_OVERHEAD)) &&
                    (el8 <= 8'(NB)) &&
                    ((el8 == 8'd0) || (epc_end <= 9'(nfill)));

  assign fm_waddr = idx;
  assign fm_raddr = FW'(uhfdd_pkg::EPC_START) + FW'(k_q);

  // Row compare: length and the first el_q bytes.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      byte_eq[b] = (EW'(b) >= el_q) || (tm_rdata_q[8*b +: 8] == buf_q[b]);
    end
    for (int b = 0; b < NB; b++) begin
      tm_wdata[8*b +: 8] = buf_q[b];
    end
    tm_wdata[RW-1 -: EW] = el_q;
  end
  assign match = (tm_rdata_q[RW-1 -: EW] == el_q) && (&byte_eq);

  assign item_cnt  = (el_q == '0) ? (EW+1)'(1) : {1'b0, el_q};
  assign last_item = ({1'b0, j_q} + (EW+1)'(1)) == item_cnt;
  assign out_byte  = (el_q == '0) ? 8'd0 : buf_q[j_q[PW-1:0]];

  always_comb begin
    st_d     = st_q;
    status_d = status_q;
    recv_d   = recv_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    el_d     = el_q;
    k_d      = k_q;
    i_d      = i_q;
    slot_d   = slot_q;
    j_d      = j_q;
    out_v_d  = out_v_q && !tx_o.ready;
    fm_we    = 1'b0;
    tm_we    = 1'b0;
    out_ld   = 1'b0;
    unique case (st_q)
      uhfdd_pkg::ST_IDLE: begin
        if (rx_acc && rx_i.command == uhfdd_pkg::CMD_CLEAR) begin
          cnt_d = '0;
        end else if (rx_acc && is_recv) begin
          fm_we = 1'b1;
          if (close) begin
            recv_d = 1'b0;
            fill_d = '0;
            if (frame_ok) begin
              el_d = EW'(el8);
              k_d  = '0;
              i_d  = '0;
              st_d = (el8 == 8'd0) ? uhfdd_pkg::ST_SRD : uhfdd_pkg::ST_LRD;
            end
          end else if (nfill >= (FW+1)'(uhfdd_pkg::DROP_LIMIT)) begin
            recv_d = 1'b0;
            fill_d = '0;
          end else begin
            recv_d = 1'b1;
            fill_d = nfill[FW-1:0];
          end
        end
      end
      uhfdd_pkg::ST_LRD: begin
        st_d = uhfdd_pkg::ST_LWR;
      end
      uhfdd_pkg::ST_LWR: begin
        k_d  = k_q + EW'(1);
        st_d = (k_q + EW'(1) == el_q) ? uhfdd_pkg::ST_SRD : uhfdd_pkg::ST_LRD;
      end
      uhfdd_pkg::ST_SRD: begin
        st_d = (i_q < cnt_q) ? uhfdd_pkg::ST_SCMP : uhfdd_pkg::ST_DECIDE;
      end
      uhfdd_pkg::ST_SCMP: begin
        if (match) begin
          status_d = uhfdd_pkg::STATUS_PRESENT;
          slot_d   = i_q[SW-1:0];
          j_d      = '0;
          st_d     = uhfdd_pkg::ST_EMIT;
        end else begin
          i_d  = i_q + CW'(1);
          st_d = uhfdd_pkg::ST_SRD;
        end
      end
      uhfdd_pkg::ST_DECIDE: begin
        if (cnt_q < CW'(uhfdd_pkg::MAX_TAG_ENTRIES)) begin
          tm_we    = 1'b1;
          slot_d   = cnt_q[SW-1:0];
          cnt_d    = cnt_q + CW'(1);
          status_d = uhfdd_pkg::STATUS_NEW;
        end else begin
          slot_d   = '0;
          status_d = uhfdd_pkg::STATUS_FULL;
        end
        j_d  = '0;
        st_d = uhfdd_pkg::ST_EMIT;
      end
      uhfdd_pkg::ST_EMIT: begin
        if (!out_v_q || tx_o.ready) begin
          out_ld  = 1'b1;
          out_v_d = 1'b1;
          j_d     = j_q + EW'(1);
          if (last_item) begin
            st_d = uhfdd_pkg::ST_IDLE;
          end
        end
      end
      default: st_d = uhfdd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= uhfdd_pkg::ST_IDLE;
      status_q <= uhfdd_pkg::STATUS_NEW;
      recv_q   <= 1'b0;
      fill_q   <= '0;
      cnt_q    <= '0;
      el_q     <= '0;
      k_q      <= '0;
      i_q      <= '0;
      slot_q   <= '0;
      j_q      <= '0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      status_q <= status_d;
      recv_q   <= recv_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      el_q     <= el_d;
      k_q      <= k_d;
      i_q      <= i_d;
      slot_q   <= slot_d;
      j_q      <= j_d;
      out_v_q  <= out_v_d;
    end
  end

  // Header fields are caught as they pass, the EPC is copied out later.
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fmem[fm_waddr] <= rx_i.rx_byte;
      if (idx == FW'(uhfdd_pkg::TYPE_POS)) type_q <= rx_i.rx_byte;
      if (idx == FW'(uhfdd_pkg::CMD_POS))  cmd_q  <= rx_i.rx_byte;
      if (idx == FW'(uhfdd_pkg::LEN_POS))  dlen_q <= rx_i.rx_byte;
    end
    fm_rdata_q <= fmem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == uhfdd_pkg::ST_LWR) begin
      buf_q[k_q[PW-1:0]] <= fm_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) begin
      tmem[cnt_q[SW-1:0]] <= tm_wdata;
    end
    tm_rdata_q <= tmem[i_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      tx_o.status        <= status_q;
      tx_o.slot          <= uhfdd_pkg::SLOT_OUT_W'(slot_q);
      tx_o.epc_length    <= uhfdd_pkg::LEN_OUT_W'(el_q);
      tx_o.byte_position <= uhfdd_pkg::POS_OUT_W'(j_q);
      tx_o.epc_byte      <= out_byte;
      tx_o.last          <= last_item;
    end
  end

  assign tx_o.valid = out_v_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(uhfdd_pkg::MAX_TAG_ENTRIES))
    else $error("tag count beyond table size");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && rx_i.command == uhfdd_pkg::CMD_CLEAR) |=> (cnt_q == '0))
    else $error("clear did not empty the table");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && last_item) |=> (st_q == uhfdd_pkg::ST_IDLE && tx_o.last))
    else $error("report did not end on its last beat");

endmodule
